// ===== hw/rtl/linear_diophantine_solution_count_assert.svh =====
// Assertion helpers for linear_diophantine_solution_count.sv.
`ifndef LINEAR_DIOPHANTINE_SOLUTION_COUNT_ASSERT_SVH
`define LINEAR_DIOPHANTINE_SOLUTION_COUNT_ASSERT_SVH

// Checked at every rising edge while reset is released.
`define LDSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define LDSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/ldsc_pkg.sv =====
`timescale 1ns / 1ps
package ldsc_pkg;

  localparam int W  = 32;
  localparam int UW = W + 3;
  localparam int CW = $clog2(W + 1);

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_NONE    = 2'd2;

  typedef struct packed {
    logic         start;
    logic [W-1:0] num;
    logic [W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic         busy;
    logic         done;
    logic [W-1:0] quo;
    logic [W-1:0] rem;
  } div_rsp_t;

endpackage

// ===== hw/rtl/ldsc_divu.sv =====
`timescale 1ns / 1ps
module ldsc_divu (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ldsc_pkg::div_req_t   req_i,
  output ldsc_pkg::div_rsp_t   rsp_o
);
  import ldsc_pkg::*;

  logic          busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [W:0]    sh;
  logic [W+1:0]  diff;
  logic          ge;

  assign sh   = {rem_q, quo_q[W-1]};
  assign diff = {1'b0, sh} - {2'b00, den_q};
  assign ge   = ~diff[W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W);
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = ge ? diff[W-1:0] : sh[W-1:0];
      quo_d = {quo_q[W-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== hw/rtl/linear_diophantine_solution_count.sv =====
`timescale 1ns / 1ps
// Counts the non-negative solutions (x, y) of a*x + b*y = c.
// The input beat carries a, b and c in s_axis_tdata. The output beat carries
// the status in m_axis_tuser and the gcd, the two Bezout coefficients and
// the solution count in m_axis_tdata.
// One item is worked on at a time: s_axis_tready is high only while the
// block is idle. A bit-serial divider yields one quotient bit per cycle,
// and the Bezout updates and modular products use shift-and-add, one
// multiplier bit per cycle.
// Each Euclid round is one division followed by one shift-and-add step
// per significant quotient bit; invalid input skips Euclid and goes
// straight to the output register.
// The result waits in an output register; a stalled receiver holds it,
// and a finished next item waits until that register is free.
// Reset returns the sequencer to idle and drops any pending beat.
module linear_diophantine_solution_count (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // coef_left, coef_right, target
  input  logic [95:0]   s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // divisor, bezout_left, bezout_right, solution_count, zero fill
  output logic [135:0]  m_axis_tdata,
  // status
  output logic [1:0]    m_axis_tuser
);
  import ldsc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_EDIV = 4'd1;
  localparam logic [3:0] S_EMUL = 4'd2;
  localparam logic [3:0] S_DC   = 4'd3;
  localparam logic [3:0] S_DA   = 4'd4;
  localparam logic [3:0] S_DB   = 4'd5;
  localparam logic [3:0] S_DU   = 4'd6;
  localparam logic [3:0] S_DCB  = 4'd7;
  localparam logic [3:0] S_MM   = 4'd8;
  localparam logic [3:0] S_DT   = 4'd9;
  localparam logic [3:0] S_PM   = 4'd10;
  localparam logic [3:0] S_DY   = 4'd11;
  localparam logic [3:0] S_DN   = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  logic [3:0]    st_q, st_d;
  logic [W-1:0]  a_q, a_d, b_q, b_d, c_q, c_d, r0_q, r0_d, r1_q, r1_d;
  logic [UW-1:0] u0_q, u0_d, u1_q, u1_d, v0_q, v0_d, v1_q, v1_d;
  logic [UW-1:0] accu_q, accu_d, accv_q, accv_d, mu_q, mu_d, mv_q, mv_d;
  logic [W-1:0]  qsh_q, qsh_d, cr_q, cr_d, ar_q, ar_d, br_q, br_d;
  logic [W-1:0]  mx_q, mx_d, my_q, my_d, acc_q, acc_d, xmin_q, xmin_d;
  logic [1:0]    rs_q, rs_d;
  logic [W-1:0]  rc_q, rc_d;
  logic          ov_q, ov_d;
  logic [135:0]  od_q, od_d;
  logic [1:0]    os_q, os_d;
  logic [W:0]    sum_acc, sum_mx;
  logic [W-1:0]  au;
  logic          inv;

  div_req_t dreq;
  div_rsp_t drsp;

  ldsc_divu u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign au      = u0_q[UW-1] ? W'(-u0_q) : u0_q[W-1:0];
  assign sum_acc = {1'b0, acc_q} + {1'b0, mx_q};
  assign sum_mx  = {1'b0, mx_q} + {1'b0, mx_q};
  assign inv     = (s_axis_tdata[31:0] == '0) || (s_axis_tdata[63:32] == '0) ||
                   (s_axis_tdata[31:0] == s_axis_tdata[63:32]);

  always_comb begin
    st_d = st_q;   a_d = a_q;   b_d = b_q;   c_d = c_q;
    r0_d = r0_q;   r1_d = r1_q;
    u0_d = u0_q;   u1_d = u1_q; v0_d = v0_q; v1_d = v1_q;
    accu_d = accu_q; accv_d = accv_q; mu_d = mu_q; mv_d = mv_q;
    qsh_d = qsh_q; cr_d = cr_q; ar_d = ar_q; br_d = br_q;
    mx_d = mx_q;   my_d = my_q; acc_d = acc_q; xmin_d = xmin_q;
    rs_d = rs_q;   rc_d = rc_q;
    ov_d = ov_q;   od_d = od_q; os_d = os_q;
    dreq.start = 1'b0;
    dreq.num   = r0_q;
    dreq.den   = r1_q;

    if (m_axis_tready) ov_d = 1'b0;

    unique case (st_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          a_d  = s_axis_tdata[31:0];
          b_d  = s_axis_tdata[63:32];
          c_d  = s_axis_tdata[95:64];
          r0_d = s_axis_tdata[31:0];
          r1_d = s_axis_tdata[63:32];
          u0_d = UW'(1); u1_d = '0;
          v0_d = '0;     v1_d = UW'(1);
          rc_d = '0;
          if (inv) begin
            rs_d = STATUS_INVALID;
            st_d = S_OUT;
          end else begin
            dreq.start = 1'b1;
            dreq.num   = s_axis_tdata[31:0];
            dreq.den   = s_axis_tdata[63:32];
            st_d       = S_EDIV;
          end
        end
      end
      S_EDIV: begin
        if (drsp.done) begin
          r0_d   = r1_q;
          r1_d   = drsp.rem;
          qsh_d  = drsp.quo;
          accu_d = u0_q; accv_d = v0_q;
          mu_d   = u1_q; mv_d   = v1_q;
          st_d   = S_EMUL;
        end
      end
      S_EMUL: begin
        if (qsh_q == '0) begin
          u0_d = u1_q; u1_d = accu_q;
          v0_d = v1_q; v1_d = accv_q;
          dreq.start = 1'b1;
          if (r1_q == '0) begin
            dreq.num = c_q;
            dreq.den = r0_q;
            st_d     = S_DC;
          end else begin
            st_d = S_EDIV;
          end
        end else begin
          if (qsh_q[0]) begin
            accu_d = accu_q - mu_q;
            accv_d = accv_q - mv_q;
          end
          mu_d  = {mu_q[UW-2:0], 1'b0};
          mv_d  = {mv_q[UW-2:0], 1'b0};
          qsh_d = {1'b0, qsh_q[W-1:1]};
        end
      end
      S_DC: begin
        dreq.num = a_q;
        dreq.den = r0_q;
        if (drsp.done) begin
          cr_d = drsp.quo;
          if (drsp.rem != '0) begin
            rs_d = STATUS_NONE;
            st_d = S_OUT;
          end else begin
            dreq.start = 1'b1;
            st_d       = S_DA;
          end
        end
      end
      S_DA: begin
        dreq.num = b_q;
        dreq.den = r0_q;
        if (drsp.done) begin
          ar_d       = drsp.quo;
          dreq.start = 1'b1;
          st_d       = S_DB;
        end
      end
      S_DB: begin
        dreq.num = au;
        dreq.den = drsp.quo;
        if (drsp.done) begin
          br_d       = drsp.quo;
          dreq.start = 1'b1;
          st_d       = S_DU;
        end
      end
      S_DU: begin
        dreq.num = cr_q;
        dreq.den = br_q;
        if (drsp.done) begin
          mx_d       = (u0_q[UW-1] && drsp.rem != '0) ? br_q - drsp.rem : drsp.rem;
          dreq.start = 1'b1;
          st_d       = S_DCB;
        end
      end
      S_DCB: begin
        if (drsp.done) begin
          my_d  = drsp.rem;
          acc_d = '0;
          st_d  = S_MM;
        end
      end
      S_MM: begin
        dreq.num = cr_q;
        dreq.den = ar_q;
        if (my_q == '0) begin
          xmin_d     = acc_q;
          dreq.start = 1'b1;
          st_d       = S_DT;
        end else begin
          if (my_q[0]) begin
            acc_d = (sum_acc >= {1'b0, br_q}) ? W'(sum_acc - {1'b0, br_q})
                                              : sum_acc[W-1:0];
          end
          mx_d = (sum_mx >= {1'b0, br_q}) ? W'(sum_mx - {1'b0, br_q}) : sum_mx[W-1:0];
          my_d = {1'b0, my_q[W-1:1]};
        end
      end
      S_DT: begin
        if (drsp.done) begin
          if (xmin_q > drsp.quo) begin
            rs_d = STATUS_NONE;
            st_d = S_OUT;
          end else begin
            acc_d = '0;
            mx_d  = ar_q;
            my_d  = xmin_q;
            st_d  = S_PM;
          end
        end
      end
      S_PM: begin
        dreq.num = cr_q - acc_q;
        dreq.den = br_q;
        if (my_q == '0) begin
          dreq.start = 1'b1;
          st_d       = S_DY;
        end else begin
          if (my_q[0]) acc_d = acc_q + mx_q;
          mx_d = {mx_q[W-2:0], 1'b0};
          my_d = {1'b0, my_q[W-1:1]};
        end
      end
      S_DY: begin
        dreq.num = drsp.quo;
        dreq.den = ar_q;
        if (drsp.done) begin
          dreq.start = 1'b1;
          st_d       = S_DN;
        end
      end
      S_DN: begin
        if (drsp.done) begin
          rc_d = drsp.quo + W'(1);
          rs_d = STATUS_OK;
          st_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1;
          os_d = rs_q;
          od_d = '0;
          if (rs_q != STATUS_INVALID) begin
            od_d[31:0]   = r0_q;
            od_d[64:32]  = u0_q[W:0];
            od_d[97:65]  = v0_q[W:0];
            od_d[129:98] = rc_q;
          end
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;   b_q <= b_d;   c_q <= c_d;
    r0_q <= r0_d; r1_q <= r1_d;
    u0_q <= u0_d; u1_q <= u1_d; v0_q <= v0_d; v1_q <= v1_d;
    accu_q <= accu_d; accv_q <= accv_d; mu_q <= mu_d; mv_q <= mv_d;
    qsh_q <= qsh_d; cr_q <= cr_d; ar_q <= ar_d; br_q <= br_d;
    mx_q <= mx_d; my_q <= my_d; acc_q <= acc_d; xmin_q <= xmin_d;
    rs_q <= rs_d; rc_q <= rc_d;
    od_q <= od_d; os_q <= os_d;
  end

  assign s_axis_tready = (st_q == S_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = os_q;

`include "linear_diophantine_solution_count_assert.svh"

  `LDSC_ASSERT(a_start_idle_div, dreq.start |-> !drsp.busy, "divider started while busy")
  `LDSC_ASSERT(a_accept_leaves_idle,
               (s_axis_tvalid && s_axis_tready) |=> (st_q != S_IDLE),
               "accepted beat left sequencer idle")
  `LDSC_ASSERT(a_ok_count_nonzero,
               (m_axis_tvalid && m_axis_tuser == STATUS_OK) |-> (m_axis_tdata[129:98] != '0),
               "counted status with zero count")
  `LDSC_ASSERT(a_done_waited,
               drsp.done |-> (st_q != S_IDLE && st_q != S_OUT),
               "divider result with no consumer")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import ldsc_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] divisor;
    logic [32:0] bezout_left;
    logic [32:0] bezout_right;
    logic [31:0] solution_count;
  } answer_t;

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic        known;
    answer_t     ans;
  } row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [95:0]   s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [135:0]  m_axis_tdata;
  logic [1:0]    m_axis_tuser;

  answer_t answers_due[$];
  int          errors = 0;
  bit          stim_done = 1'b0;
  bit          long_hold = 1'b0;

  linear_diophantine_solution_count DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #5 clk_i = ~clk_i;

  function automatic answer_t count_solutions(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    answer_t r;
    longint r0, r1, u0, u1, v0, v1, q, t, ums;
    longint unsigned g, ar, br, cr, um, xmin, ymax;
    r = '0;
    if (a == 0 || b == 0 || a == b) begin
      r.status = STATUS_INVALID;
      return r;
    end
    r0 = a; r1 = b; u0 = 1; u1 = 0; v0 = 0; v1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      t = r0 - q * r1; r0 = r1; r1 = t;
      t = u0 - q * u1; u0 = u1; u1 = t;
      t = v0 - q * v1; v0 = v1; v1 = t;
    end
    g = r0;
    r.divisor = g[31:0];
    r.bezout_left = u0[32:0];
    r.bezout_right = v0[32:0];
    if (c % g != 0) begin
      r.status = STATUS_NONE;
      return r;
    end
    ar = a / g; br = b / g; cr = c / g;
    ums = u0 % longint'(br);
    if (ums < 0) ums += longint'(br);
    um = ums;
    // Operands stay below 2^32, so the product fits in 64 bits.
    xmin = (um * (cr % br)) % br;
    if (xmin > cr / ar) begin
      r.status = STATUS_NONE;
      return r;
    end
    ymax = (cr - ar * xmin) / br;
    r.status = STATUS_OK;
    r.solution_count = 32'(ymax / ar + 1);
    return r;
  endfunction

  task automatic send_item(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                           logic known, answer_t ans);
    answer_t p;
    p = count_solutions(a, b, c);
    if (known && p !== ans) begin
      $error("table row a=%0d b=%0d c=%0d disagrees with predictor", a, b, c);
      errors++;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c, b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    answers_due.push_back(p);
    if ($urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 20);
      1: return $urandom_range(0, 1000);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 20);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    row_t tbl[$];
    logic [31:0] a, b, g, c;
    tbl = '{
      '{32'd0, 32'd5, 32'd7, 1'b1, '{STATUS_INVALID, 0, 0, 0, 0}},
      '{32'd5, 32'd0, 32'd7, 1'b1, '{STATUS_INVALID, 0, 0, 0, 0}},
      '{32'd9, 32'd9, 32'd9, 1'b1, '{STATUS_INVALID, 0, 0, 0, 0}},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 1'b1, '{STATUS_INVALID, 0, 0, 0, 0}},
      '{32'd0, 32'd0, 32'd0, 1'b1, '{STATUS_INVALID, 0, 0, 0, 0}},
      '{32'd1, 32'd2, 32'd0, 1'b1, '{STATUS_OK, 32'd1, 33'd1, 33'd0, 32'd1}},
      '{32'd4, 32'd6, 32'd3, 1'b0, '0},
      '{32'd4, 32'd6, 32'd2, 1'b0, '0},
      '{32'd3, 32'd5, 32'd7, 1'b0, '0},
      '{32'd3, 32'd5, 32'd8, 1'b0, '0},
      '{32'd3, 32'd5, 32'd30, 1'b0, '0},
      '{32'd1, 32'd2, 32'hFFFF_FFFF, 1'b0, '0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, '0},
      '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'd0, 1'b0, '0},
      '{32'hB5C0_FBCF, 32'h7055_5E2B, 32'hFFFF_FFFF, 1'b0, '0},
      '{32'd2971215073, 32'd1836311903, 32'd12345, 1'b0, '0},
      '{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 1'b0, '0},
      '{32'h8000_0000, 32'h4000_0000, 32'hC000_0000, 1'b0, '0}
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (tbl[i]) send_item(tbl[i].a, tbl[i].b, tbl[i].c, tbl[i].known, tbl[i].ans);
    repeat (300) begin
      a = rand_val();
      b = rand_val();
      if ($urandom_range(0, 9) < 6) begin
        // Build c as a*m + b*n for small m and n.
        c = a * $urandom_range(0, 50) + b * $urandom_range(0, 50);
      end else begin
        c = rand_val();
      end
      if ($urandom_range(0, 19) == 0) b = a;
      if ($urandom_range(0, 9) == 0) begin
        g = $urandom_range(1, 1 << $urandom_range(1, 20));
        a = g * $urandom_range(1, 4000);
        b = g * $urandom_range(1, 4000);
      end
      send_item(a, b, c, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    int hold;
    wait (rst_ni);
    repeat (200) @(posedge clk_i);
    long_hold = 1'b1;
    hold = 0;
    while (hold < 20000) begin
      @(posedge clk_i);
      hold++;
    end
    long_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    if (long_hold) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 15) < 10) || (($urandom_range(0, 7) == 0));
    end
  end

  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tuser;
      got.divisor = m_axis_tdata[31:0];
      got.bezout_left = m_axis_tdata[64:32];
      got.bezout_right = m_axis_tdata[97:65];
      got.solution_count = m_axis_tdata[129:98];
      if (answers_due.size() == 0) begin
        $error("result beat with no expectation pending");
        errors++;
      end else begin
        want = answers_due.pop_front();
        if (got.status !== want.status) begin
          $error("status exp %0d got %0d", want.status, got.status); errors++;
        end
        if (got.divisor !== want.divisor) begin
          $error("divisor exp %0d got %0d", want.divisor, got.divisor); errors++;
        end
        if (got.bezout_left !== want.bezout_left) begin
          $error("bezout_left exp %h got %h", want.bezout_left, got.bezout_left); errors++;
        end
        if (got.bezout_right !== want.bezout_right) begin
          $error("bezout_right exp %h got %h", want.bezout_right, got.bezout_right);
          errors++;
        end
        if (got.solution_count !== want.solution_count) begin
          $error("solution_count exp %0d got %0d", want.solution_count,
                 got.solution_count);
          errors++;
        end
      end
    end
  end

  initial begin
    #60ms;
    $display("tb: done, errors");
    $finish;
  end

endmodule
